FILE: hw/rtl/g2e_pkg.sv
// Shared types and constants for the geodetic to ENU frame transform.
// Used by the top level, g2e_cordic_cell and g2e_div_cell; no dependencies.
package g2e_pkg;

	localparam int TRIG_STAGES_DEF = 32;
	localparam int ROOT_STEPS      = 32;
	localparam int DIV_BITS        = 35;
	localparam int IN_W            = 96;
	localparam int OUT_W           = 400;
	localparam int AX_W            = 32;
	localparam int POS_W           = 37;

	localparam logic [2:0] ADDR_MODE = 3'd0;

	localparam logic signed [63:0] Q22_HALF_TURN    = 64'sd754974720;
	localparam logic signed [63:0] Q22_FULL_TURN    = 64'sd1509949440;
	localparam logic signed [63:0] Q22_QUARTER_TURN = 64'sd377487360;
	localparam logic signed [63:0] Q22_SIXTY_DEG    = 64'sd251658240;
	localparam logic signed [63:0] PI_OVER_4_Q60    = 64'sd905502432259640355;
	localparam logic signed [63:0] DEG_TO_RAD_Q62   = 64'sd80489105089745809;
	localparam logic signed [63:0] CORDIC_START_Q60 = 64'sd700114967507363238;
	localparam logic signed [63:0] ONE_Q62          = 64'sd4611686018427387904;
	localparam logic signed [63:0] E2_Q62           = 64'sd30872378602574781;
	localparam logic signed [63:0] DENOM_FLOOR_Q62  = 64'sd4611686;
	localparam logic signed [63:0] WGS84_A_MM       = 64'sd6378137000;
	localparam logic signed [63:0] SPHERE_R_MM      = 64'sd6371000000;
	localparam logic signed [63:0] AXIS_LIMIT       = 64'sd1073741824;
	localparam logic signed [63:0] POS_MAX          = 64'sd68719476735;
	localparam logic signed [63:0] POS_MIN          = -64'sd68719476736;

	// a << 31 as the fixed dividend of the normal-radius divide
	localparam logic [63:0] DIV_NUM  = 64'd6378137000 << 31;
	localparam logic [31:0] DIV_REM0 = 32'(DIV_NUM >> DIV_BITS);

	typedef struct packed {
		logic signed [31:0] alt;
		logic               far;
		logic               flip_lon;
		logic               flip_lat;
		logic signed [63:0] slon;
		logic signed [63:0] clon;
		logic signed [63:0] slat;
		logic signed [63:0] clat;
		logic [7:0][31:0]   ax;
		logic signed [63:0] sq;
		logic signed [63:0] t1;
		logic signed [63:0] t2;
		logic signed [63:0] fac;
		logic signed [63:0] denom;
		logic signed [63:0] nser;
		logic signed [63:0] nroot;
		logic signed [63:0] pxy;
		logic signed [63:0] pz;
		logic signed [63:0] t;
	} rec_t;

endpackage

FILE: hw/rtl/geodetic_to_enu_frame_transform_top.sv
// Top level of the geodetic to ENU frame transform.
// Depends on g2e_pkg, g2e_mul, g2e_cordic_cell, g2e_root_cell, g2e_div_cell.
//
// Usage:
//   Input stream s_*: one item = longitude, latitude (Q22 degrees), altitude (mm).
//   Output stream m_*: one item per input = east/north/up axes (Q1.30) and the
//   Earth-centred origin (mm, saturated to 37 bits).
//   APB port: register ellipsoid_mode at byte address 0 (1 = WGS84, 0 = sphere).
//   Write it only while the pipeline is empty.
// Throughput: one item per cycle while the output is not stalled. The whole
//   datapath is a single stalling pipeline: two CORDIC chains of TRIG_STAGES
//   cells, a 32-cell square root chain, a 35-cell divider chain and two-stage
//   multipliers.
// Reset: all valid flags clear, ellipsoid_mode returns to 1.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds and
//   s_tready drops; the output register keeps its item until taken, and a new
//   item is accepted in the same cycle the held one leaves.
module geodetic_to_enu_frame_transform_top #(
	parameter int TRIG_STAGES = g2e_pkg::TRIG_STAGES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [g2e_pkg::IN_W-1:0]   s_tdata,  // longitude[30:0], latitude[60:31], altitude[92:61]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [g2e_pkg::OUT_W-1:0]  m_tdata,  // east_x/y/z, north_x/y/z, up_x/y/z (32 each), origin_x/y/z (37 each)
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	typedef struct packed {
		logic signed [32:0] d;
		logic               flip;
	} ang_t;

	localparam int RW = $bits(g2e_pkg::rec_t);

	function automatic ang_t wrap_angle(input logic signed [32:0] a);
		logic signed [63:0] d;
		ang_t r;
		d = 64'(a);
		r.flip = 1'b0;
		if (d >= g2e_pkg::Q22_HALF_TURN)
			d = d - g2e_pkg::Q22_FULL_TURN;
		else if (d < -g2e_pkg::Q22_HALF_TURN)
			d = d + g2e_pkg::Q22_FULL_TURN;
		if (d > g2e_pkg::Q22_QUARTER_TURN) begin
			d = d - g2e_pkg::Q22_HALF_TURN;
			r.flip = 1'b1;
		end else if (d < -g2e_pkg::Q22_QUARTER_TURN) begin
			d = d + g2e_pkg::Q22_HALF_TURN;
			r.flip = 1'b1;
		end
		r.d = d[32:0];
		return r;
	endfunction

	function automatic logic [31:0] axs(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = (v + 64'sd536870912) >>> 30;
		if (r > g2e_pkg::AXIS_LIMIT)
			r = g2e_pkg::AXIS_LIMIT;
		else if (r < -g2e_pkg::AXIS_LIMIT)
			r = -g2e_pkg::AXIS_LIMIT;
		return r[31:0];
	endfunction

	function automatic logic [g2e_pkg::POS_W-1:0] poss(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (r > g2e_pkg::POS_MAX)
			r = g2e_pkg::POS_MAX;
		else if (r < g2e_pkg::POS_MIN)
			r = g2e_pkg::POS_MIN;
		return r[g2e_pkg::POS_W-1:0];
	endfunction

	// configuration
	logic mode_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == g2e_pkg::ADDR_MODE[2]);
	assign prdata = (paddr[2] == g2e_pkg::ADDR_MODE[2]) ? {31'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b1;
		else if (cfg_wr)
			mode_q <= pwdata[0];
	end

	// pipeline advance
	logic out_vld_q;
	logic en;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;

	// stage 1: angle wrap and quadrant fold
	ang_t               alon;
	ang_t               alat;
	g2e_pkg::rec_t      rec_in;
	g2e_pkg::rec_t      r_s1;
	logic signed [32:0] dlon_s1;
	logic signed [32:0] dlat_s1;
	logic               vld_s1;
	logic signed [63:0] lat_raw;

	assign lat_raw = 64'($signed(s_tdata[60:31]));
	assign alon    = wrap_angle(33'($signed(s_tdata[30:0])));
	assign alat    = wrap_angle(33'($signed(s_tdata[60:31])));

	always_comb begin
		rec_in          = '0;
		rec_in.alt      = $signed(s_tdata[92:61]);
		rec_in.far      = (lat_raw > g2e_pkg::Q22_SIXTY_DEG) || (lat_raw < -g2e_pkg::Q22_SIXTY_DEG);
		rec_in.flip_lon = alon.flip;
		rec_in.flip_lat = alat.flip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1    <= rec_in;
			dlon_s1 <= alon.d;
			dlat_s1 <= alat.d;
		end
	end

	// degrees to radians
	logic               vld_g1;
	logic signed [63:0] zlon;
	logic signed [63:0] zlat;
	g2e_pkg::rec_t      r_g1;

	g2e_mul #(.SH(24), .SIDE_W(RW)) u_zlon (
		.clk, .arst_n, .en, .vld_i(vld_s1), .a(64'(dlon_s1)), .b(g2e_pkg::DEG_TO_RAD_Q62),
		.side_i(r_s1), .vld_o(vld_g1), .p(zlon), .side_o(r_g1));
	g2e_mul #(.SH(24), .SIDE_W(1)) u_zlat (
		.clk, .arst_n, .en, .vld_i(vld_s1), .a(64'(dlat_s1)), .b(g2e_pkg::DEG_TO_RAD_Q62),
		.side_i(1'b0), .vld_o(), .p(zlat), .side_o());

	// CORDIC chains
	logic signed [63:0] lx [TRIG_STAGES+1];
	logic signed [63:0] ly [TRIG_STAGES+1];
	logic signed [63:0] lz [TRIG_STAGES+1];
	logic               lv [TRIG_STAGES+1];
	g2e_pkg::rec_t      lr [TRIG_STAGES+1];
	logic signed [63:0] ax_ [TRIG_STAGES+1];
	logic signed [63:0] ay_ [TRIG_STAGES+1];
	logic signed [63:0] az_ [TRIG_STAGES+1];

	assign lx[0]  = g2e_pkg::CORDIC_START_Q60;
	assign ly[0]  = '0;
	assign lz[0]  = zlon;
	assign lv[0]  = vld_g1;
	assign lr[0]  = r_g1;
	assign ax_[0] = g2e_pkg::CORDIC_START_Q60;
	assign ay_[0] = '0;
	assign az_[0] = zlat;

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cordic
		g2e_cordic_cell #(.IDX(i), .SIDE_W(RW)) u_lon (
			.clk, .arst_n, .en, .vld_i(lv[i]), .x_i(lx[i]), .y_i(ly[i]), .z_i(lz[i]),
			.side_i(lr[i]), .vld_o(lv[i+1]), .x_o(lx[i+1]), .y_o(ly[i+1]), .z_o(lz[i+1]),
			.side_o(lr[i+1]));
		g2e_cordic_cell #(.IDX(i), .SIDE_W(1)) u_lat (
			.clk, .arst_n, .en, .vld_i(1'b0), .x_i(ax_[i]), .y_i(ay_[i]), .z_i(az_[i]),
			.side_i(1'b0), .vld_o(), .x_o(ax_[i+1]), .y_o(ay_[i+1]), .z_o(az_[i+1]),
			.side_o());
	end

	// stage 2: quadrant unfold
	g2e_pkg::rec_t rec2;
	g2e_pkg::rec_t r_s2;
	logic          vld_s2;

	always_comb begin
		rec2      = lr[TRIG_STAGES];
		rec2.slon = rec2.flip_lon ? -ly[TRIG_STAGES] : ly[TRIG_STAGES];
		rec2.clon = rec2.flip_lon ? -lx[TRIG_STAGES] : lx[TRIG_STAGES];
		rec2.slat = rec2.flip_lat ? -ay_[TRIG_STAGES] : ay_[TRIG_STAGES];
		rec2.clat = rec2.flip_lat ? -ax_[TRIG_STAGES] : ax_[TRIG_STAGES];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s2 <= 1'b0;
		else if (en)
			vld_s2 <= lv[TRIG_STAGES];
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s2 <= rec2;
	end

	// axis products and sin^2 lat
	logic               vld_g3;
	g2e_pkg::rec_t      r_g3;
	logic signed [63:0] p_sc;
	logic signed [63:0] p_ss;
	logic signed [63:0] p_cc;
	logic signed [63:0] p_cs;
	logic signed [63:0] p_sq;

	g2e_mul #(.SH(60), .SIDE_W(RW)) u_sc (
		.clk, .arst_n, .en, .vld_i(vld_s2), .a(r_s2.slat), .b(r_s2.clon),
		.side_i(r_s2), .vld_o(vld_g3), .p(p_sc), .side_o(r_g3));
	g2e_mul #(.SH(60), .SIDE_W(1)) u_ss (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s2.slat), .b(r_s2.slon),
		.side_i(1'b0), .vld_o(), .p(p_ss), .side_o());
	g2e_mul #(.SH(60), .SIDE_W(1)) u_cc (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s2.clat), .b(r_s2.clon),
		.side_i(1'b0), .vld_o(), .p(p_cc), .side_o());
	g2e_mul #(.SH(60), .SIDE_W(1)) u_cs (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s2.clat), .b(r_s2.slon),
		.side_i(1'b0), .vld_o(), .p(p_cs), .side_o());
	g2e_mul #(.SH(58), .SIDE_W(1)) u_sq (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s2.slat), .b(r_s2.slat),
		.side_i(1'b0), .vld_o(), .p(p_sq), .side_o());

	// stage 3: axis rounding and clamp
	g2e_pkg::rec_t rec3;
	g2e_pkg::rec_t r_s3;
	logic          vld_s3;

	always_comb begin
		rec3       = r_g3;
		rec3.ax[0] = axs(-rec3.slon);
		rec3.ax[1] = axs(rec3.clon);
		rec3.ax[2] = axs(-p_sc);
		rec3.ax[3] = axs(-p_ss);
		rec3.ax[4] = axs(rec3.clat);
		rec3.ax[5] = axs(p_cc);
		rec3.ax[6] = axs(p_cs);
		rec3.ax[7] = axs(rec3.slat);
		rec3.sq    = p_sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s3 <= 1'b0;
		else if (en)
			vld_s3 <= vld_g3;
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s3 <= rec3;
	end

	// t1 = e2 * sin^2
	logic               vld_g4;
	g2e_pkg::rec_t      r_g4;
	logic signed [63:0] p_t1;

	g2e_mul #(.SH(62), .SIDE_W(RW)) u_t1 (
		.clk, .arst_n, .en, .vld_i(vld_s3), .a(g2e_pkg::E2_Q62), .b(r_s3.sq),
		.side_i(r_s3), .vld_o(vld_g4), .p(p_t1), .side_o(r_g4));

	// stage 4: denominator with floor
	g2e_pkg::rec_t      rec4;
	g2e_pkg::rec_t      r_s4;
	logic               vld_s4;
	logic signed [63:0] dn;

	assign dn = g2e_pkg::ONE_Q62 - p_t1;

	always_comb begin
		rec4       = r_g4;
		rec4.t1    = p_t1;
		rec4.denom = (dn < g2e_pkg::DENOM_FLOOR_Q62) ? g2e_pkg::DENOM_FLOOR_Q62 : dn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else if (en)
			vld_s4 <= vld_g4;
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s4 <= rec4;
	end

	// series terms t2, t3
	logic               vld_g5;
	g2e_pkg::rec_t      r_g5;
	g2e_pkg::rec_t      rec5;
	logic signed [63:0] p_t2;
	logic               vld_g6;
	g2e_pkg::rec_t      r_g6;
	logic signed [63:0] p_t3;

	g2e_mul #(.SH(62), .SIDE_W(RW)) u_t2 (
		.clk, .arst_n, .en, .vld_i(vld_s4), .a(r_s4.t1), .b(r_s4.t1),
		.side_i(r_s4), .vld_o(vld_g5), .p(p_t2), .side_o(r_g5));

	always_comb begin
		rec5    = r_g5;
		rec5.t2 = p_t2;
	end

	g2e_mul #(.SH(62), .SIDE_W(RW)) u_t3 (
		.clk, .arst_n, .en, .vld_i(vld_g5), .a(rec5.t2), .b(rec5.t1),
		.side_i(rec5), .vld_o(vld_g6), .p(p_t3), .side_o(r_g6));

	// stage 7: series factor
	g2e_pkg::rec_t rec7;
	g2e_pkg::rec_t r_s7;
	logic          vld_s7;

	always_comb begin
		rec7     = r_g6;
		rec7.fac = g2e_pkg::ONE_Q62 + (rec7.t1 >>> 1)
			+ ((rec7.t2 + (rec7.t2 <<< 1)) >>> 3)
			+ ((p_t3 + (p_t3 <<< 2)) >>> 4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s7 <= 1'b0;
		else if (en)
			vld_s7 <= vld_g6;
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s7 <= rec7;
	end

	// series normal radius
	logic               vld_g8;
	g2e_pkg::rec_t      r_g8;
	g2e_pkg::rec_t      rec8;
	logic signed [63:0] p_ns;

	g2e_mul #(.SH(62), .SIDE_W(RW)) u_ns (
		.clk, .arst_n, .en, .vld_i(vld_s7), .a(g2e_pkg::WGS84_A_MM), .b(r_s7.fac),
		.side_i(r_s7), .vld_o(vld_g8), .p(p_ns), .side_o(r_g8));

	always_comb begin
		rec8      = r_g8;
		rec8.nser = p_ns;
	end

	// square root chain
	logic [63:0]   rrem [g2e_pkg::ROOT_STEPS+1];
	logic [63:0]   rres [g2e_pkg::ROOT_STEPS+1];
	logic          rv   [g2e_pkg::ROOT_STEPS+1];
	g2e_pkg::rec_t rr   [g2e_pkg::ROOT_STEPS+1];

	assign rrem[0] = rec8.denom;
	assign rres[0] = '0;
	assign rv[0]   = vld_g8;
	assign rr[0]   = rec8;

	for (genvar k = 0; k < g2e_pkg::ROOT_STEPS; k++) begin : g_root
		g2e_root_cell #(.K(k), .SIDE_W(RW)) u_cell (
			.clk, .arst_n, .en, .vld_i(rv[k]), .rem_i(rrem[k]), .res_i(rres[k]),
			.side_i(rr[k]), .vld_o(rv[k+1]), .rem_o(rrem[k+1]), .res_o(rres[k+1]),
			.side_o(rr[k+1]));
	end

	// divide chain
	logic [31:0]                  drem [g2e_pkg::DIV_BITS+1];
	logic [31:0]                  dd   [g2e_pkg::DIV_BITS+1];
	logic [g2e_pkg::DIV_BITS-1:0] dq   [g2e_pkg::DIV_BITS+1];
	logic                         dv   [g2e_pkg::DIV_BITS+1];
	g2e_pkg::rec_t                dr   [g2e_pkg::DIV_BITS+1];

	assign drem[0] = g2e_pkg::DIV_REM0;
	assign dd[0]   = rres[g2e_pkg::ROOT_STEPS][31:0];
	assign dq[0]   = '0;
	assign dv[0]   = rv[g2e_pkg::ROOT_STEPS];
	assign dr[0]   = rr[g2e_pkg::ROOT_STEPS];

	for (genvar k = 0; k < g2e_pkg::DIV_BITS; k++) begin : g_div
		g2e_div_cell #(.K(k), .SIDE_W(RW)) u_cell (
			.clk, .arst_n, .en, .vld_i(dv[k]), .rem_i(drem[k]), .d_i(dd[k]), .q_i(dq[k]),
			.side_i(dr[k]), .vld_o(dv[k+1]), .rem_o(drem[k+1]), .d_o(dd[k+1]),
			.q_o(dq[k+1]), .side_o(dr[k+1]));
	end

	// stage 11: radius select
	g2e_pkg::rec_t      rec11;
	g2e_pkg::rec_t      r_s11;
	logic               vld_s11;
	logic signed [63:0] nxy;

	always_comb begin
		rec11       = dr[g2e_pkg::DIV_BITS];
		rec11.nroot = $signed(64'(dq[g2e_pkg::DIV_BITS]));
		nxy         = rec11.far ? rec11.nser : rec11.nroot;
		rec11.pxy   = mode_q ? nxy + 64'(rec11.alt) : g2e_pkg::SPHERE_R_MM + 64'(rec11.alt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s11 <= 1'b0;
		else if (en)
			vld_s11 <= dv[g2e_pkg::DIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s11 <= rec11;
	end

	// polar radius and horizontal projection
	logic               vld_g12;
	g2e_pkg::rec_t      r_g12;
	logic signed [63:0] p_pz;
	logic signed [63:0] p_tt;

	g2e_mul #(.SH(62), .SIDE_W(RW)) u_pz (
		.clk, .arst_n, .en, .vld_i(vld_s11), .a(r_s11.nroot),
		.b(g2e_pkg::ONE_Q62 - g2e_pkg::E2_Q62),
		.side_i(r_s11), .vld_o(vld_g12), .p(p_pz), .side_o(r_g12));
	g2e_mul #(.SH(44), .SIDE_W(1)) u_tt (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s11.pxy), .b(r_s11.clat),
		.side_i(1'b0), .vld_o(), .p(p_tt), .side_o());

	// stage 13
	g2e_pkg::rec_t rec13;
	g2e_pkg::rec_t r_s13;
	logic          vld_s13;

	always_comb begin
		rec13    = r_g12;
		rec13.pz = mode_q ? p_pz + 64'(rec13.alt) : rec13.pxy;
		rec13.t  = p_tt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s13 <= 1'b0;
		else if (en)
			vld_s13 <= vld_g12;
	end

	always_ff @(posedge clk) begin
		if (en)
			r_s13 <= rec13;
	end

	// ECEF position products
	logic               vld_g14;
	g2e_pkg::rec_t      r_g14;
	logic signed [63:0] p_mx;
	logic signed [63:0] p_my;
	logic signed [63:0] p_mz;

	g2e_mul #(.SH(60), .SIDE_W(RW)) u_mx (
		.clk, .arst_n, .en, .vld_i(vld_s13), .a(r_s13.t), .b(r_s13.clon),
		.side_i(r_s13), .vld_o(vld_g14), .p(p_mx), .side_o(r_g14));
	g2e_mul #(.SH(60), .SIDE_W(1)) u_my (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s13.t), .b(r_s13.slon),
		.side_i(1'b0), .vld_o(), .p(p_my), .side_o());
	g2e_mul #(.SH(60), .SIDE_W(1)) u_mz (
		.clk, .arst_n, .en, .vld_i(1'b0), .a(r_s13.pz), .b(r_s13.slat),
		.side_i(1'b0), .vld_o(), .p(p_mz), .side_o());

	// output register
	logic [g2e_pkg::OUT_W-1:0] out_d;
	logic [g2e_pkg::OUT_W-1:0] tdata_q;

	always_comb begin
		out_d = {1'b0,
			poss(p_mz),
			poss((p_my + 64'sd32768) >>> 16),
			poss((p_mx + 64'sd32768) >>> 16),
			r_g14.ax[7], r_g14.ax[6], r_g14.ax[5],
			r_g14.ax[4], r_g14.ax[3], r_g14.ax[2],
			32'd0, r_g14.ax[1], r_g14.ax[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_g14;
	end

	always_ff @(posedge clk) begin
		if (en)
			tdata_q <= out_d;
	end

	assign m_tdata = tdata_q;

	// checks
	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_s1)
		else $error("accepted item missing from first stage");

	a_east_z_zero : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[95:64] == 32'd0))
		else $error("east_z not zero");

	a_axis_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824
			&& $signed(m_tdata[31:0]) >= -32'sd1073741824))
		else $error("east_x outside clamp range");

endmodule

FILE: hw/rtl/g2e_mul.sv
// Two-stage 64x64 signed multiply, rounded shift right by SH, 64-bit result.
// Carries a side payload alongside. Depends on nothing.
module g2e_mul #(
	parameter int SH     = 60,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic signed [63:0]       a,
	input  logic signed [63:0]       b,
	input  logic [SIDE_W-1:0]        side_i,
	output logic                     vld_o,
	output logic signed [63:0]       p,
	output logic [SIDE_W-1:0]        side_o
);
	localparam logic signed [127:0] RND = 128'sd1 <<< (SH - 1);

	logic                vld_s1;
	logic [63:0]         pll_s1;
	logic signed [64:0]  plh_s1;
	logic signed [64:0]  phl_s1;
	logic signed [63:0]  phh_s1;
	logic [SIDE_W-1:0]   side_s1;
	logic signed [127:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_o  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_o  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1  <= a[31:0] * b[31:0];
			plh_s1  <= $signed({1'b0, a[31:0]}) * $signed(b[63:32]);
			phl_s1  <= $signed(a[63:32]) * $signed({1'b0, b[31:0]});
			phh_s1  <= $signed(a[63:32]) * $signed(b[63:32]);
			side_s1 <= side_i;
			p       <= sum[SH+63:SH];
			side_o  <= side_s1;
		end
	end

	always_comb begin
		sum = $signed({64'd0, pll_s1})
			+ ($signed({{63{plh_s1[64]}}, plh_s1}) <<< 32)
			+ ($signed({{63{phl_s1[64]}}, phl_s1}) <<< 32)
			+ ($signed({{64{phh_s1[63]}}, phh_s1}) <<< 64)
			+ RND;
	end

endmodule

FILE: hw/rtl/g2e_cordic_cell.sv
// One rotation-mode CORDIC stage in Q60, atan constant built at elaboration.
// Depends on g2e_pkg.
module g2e_cordic_cell #(
	parameter int IDX    = 0,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld_i,
	input  logic signed [63:0]       x_i,
	input  logic signed [63:0]       y_i,
	input  logic signed [63:0]       z_i,
	input  logic [SIDE_W-1:0]        side_i,
	output logic                     vld_o,
	output logic signed [63:0]       x_o,
	output logic signed [63:0]       y_o,
	output logic signed [63:0]       z_o,
	output logic [SIDE_W-1:0]        side_o
);
	function automatic logic [63:0] pow2_div(input int e, input int n);
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] r;
		num = 64'd1 << e;
		q = '0;
		r = '0;
		for (int bi = 63; bi >= 0; bi--) begin
			r = {r[62:0], num[bi]};
			if (r >= 64'(n)) begin
				r = r - 64'(n);
				q[bi] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] atan_q60(input int i);
		logic signed [63:0] acc;
		acc = '0;
		if (i == 0)
			return g2e_pkg::PI_OVER_4_Q60;
		for (int k = 0; k < 31; k++) begin
			if (i * (2 * k + 1) <= 60) begin
				if (k % 2 == 1)
					acc = acc - $signed(pow2_div(60 - i * (2 * k + 1), 2 * k + 1));
				else
					acc = acc + $signed(pow2_div(60 - i * (2 * k + 1), 2 * k + 1));
			end
		end
		return acc;
	endfunction

	localparam logic signed [63:0] ATAN = atan_q60(IDX);

	logic signed [63:0] xs;
	logic signed [63:0] ys;

	assign xs = x_i >>> IDX;
	assign ys = y_i >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			if (z_i >= 0) begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - ATAN;
			end else begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + ATAN;
			end
		end
	end

endmodule

FILE: hw/rtl/g2e_root_cell.sv
// One step of the bitwise integer square root (two radicand bits per cell).
// Depends on nothing.
module g2e_root_cell #(
	parameter int K      = 0,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [63:0]       rem_i,
	input  logic [63:0]       res_i,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [63:0]       rem_o,
	output logic [63:0]       res_o,
	output logic [SIDE_W-1:0] side_o
);
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * K);

	logic [63:0] trial;

	assign trial = res_i + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			if (rem_i >= trial) begin
				rem_o <= rem_i - trial;
				res_o <= (res_i >> 1) + BIT;
			end else begin
				rem_o <= rem_i;
				res_o <= res_i >> 1;
			end
		end
	end

endmodule

FILE: hw/rtl/g2e_div_cell.sv
// One restoring-division step of (a << 31) / root, one quotient bit per cell.
// Depends on g2e_pkg.
module g2e_div_cell #(
	parameter int K      = 0,
	parameter int SIDE_W = 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  logic [31:0]                   rem_i,
	input  logic [31:0]                   d_i,
	input  logic [g2e_pkg::DIV_BITS-1:0]  q_i,
	input  logic [SIDE_W-1:0]             side_i,
	output logic                          vld_o,
	output logic [31:0]                   rem_o,
	output logic [31:0]                   d_o,
	output logic [g2e_pkg::DIV_BITS-1:0]  q_o,
	output logic [SIDE_W-1:0]             side_o
);
	localparam logic NB = g2e_pkg::DIV_NUM[g2e_pkg::DIV_BITS-1-K];

	logic [32:0] shr;
	logic        ge;

	assign shr = {rem_i, NB};
	assign ge  = shr >= {1'b0, d_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_o <= 1'b0;
		else if (en)
			vld_o <= vld_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_o <= side_i;
			d_o    <= d_i;
			q_o    <= {q_i[g2e_pkg::DIV_BITS-2:0], ge};
			rem_o  <= ge ? 32'(shr - {1'b0, d_i}) : shr[31:0];
		end
	end

endmodule

FILE: test/geodetic_to_enu_frame_transform_top_tb.sv
// Testbench for geodetic_to_enu_frame_transform_top: random and directed position fixes
// checked against a bit-exact fixed-point predictor. Depends on g2e_pkg and the RTL.
`timescale 1ns / 1ps

module geodetic_to_enu_frame_transform_top_tb;
	import g2e_pkg::*;

	localparam int NUM_RANDOM = 730;
	localparam int LATENCY    = TRIG_STAGES_DEF + 91;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [31:0] alt;
		logic signed [29:0] lat;
		logic signed [30:0] lon;
	} fix_t;

	typedef struct {
		logic signed [31:0] ax[9];
		logic signed [36:0] org[3];
	} frame_t;

	class frame_scoreboard;
		frame_t pending[$];
		bit     ellipsoid;
		int     errors;
		int     checked;

		function new();
			ellipsoid = 1;
		endfunction

		static function longint asr(longint v, int n);
			return v >>> n;
		endfunction

		static function longint rnd(longint v, int n);
			return (v + (longint'(1) << (n - 1))) >>> n;
		endfunction

		static function longint mulr(longint a, longint b, int sh);
			logic signed [127:0] p;
			p = 128'(a) * 128'(b);
			p = p + (128'sd1 <<< (sh - 1));
			p = p >>> sh;
			return p[63:0];
		endfunction

		static function longint atan_entry(int i);
			longint acc;
			longint term;
			acc = 0;
			if (i == 0)
				return PI_OVER_4_Q60;
			for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
				term = (longint'(1) << (60 - i * (2 * k + 1))) / (2 * k + 1);
				acc += (k % 2) ? -term : term;
			end
			return acc;
		endfunction

		static function void sin_cos(longint d, output longint s, output longint c);
			bit flip;
			longint x, y, z, xs, ys, a;
			flip = 0;
			x = CORDIC_START_Q60;
			y = 0;
			if (d >= Q22_HALF_TURN) d -= Q22_FULL_TURN;
			else if (d < -Q22_HALF_TURN) d += Q22_FULL_TURN;
			if (d > Q22_QUARTER_TURN) begin
				d -= Q22_HALF_TURN;
				flip = 1;
			end else if (d < -Q22_QUARTER_TURN) begin
				d += Q22_HALF_TURN;
				flip = 1;
			end
			z = mulr(d, DEG_TO_RAD_Q62, 24);
			for (int i = 0; i < TRIG_STAGES_DEF; i++) begin
				xs = asr(x, i);
				ys = asr(y, i);
				a = atan_entry(i);
				if (z >= 0) begin
					x -= ys; y += xs; z -= a;
				end else begin
					x += ys; y -= xs; z += a;
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		static function longint unsigned floor_root(longint unsigned v);
			longint unsigned rem, res, b;
			rem = v;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (rem >= res + b) begin
					rem -= res + b;
					res = (res >> 1) + b;
				end else
					res >>= 1;
				b >>= 2;
			end
			return res;
		endfunction

		static function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function frame_t transform(fix_t f);
			frame_t r;
			longint slon, clon, slat, clat, lat, pxy, pz, t, t1, t2, t3, fac, denom;
			longint nroot, nxy;
			longint ax[9];
			longint pos[3];
			longint unsigned root;
			lat = f.lat;
			sin_cos(longint'(f.lon), slon, clon);
			sin_cos(lat, slat, clat);
			ax[0] = -slon;
			ax[1] = clon;
			ax[2] = 0;
			ax[3] = -mulr(slat, clon, 60);
			ax[4] = -mulr(slat, slon, 60);
			ax[5] = clat;
			ax[6] = mulr(clat, clon, 60);
			ax[7] = mulr(clat, slon, 60);
			ax[8] = slat;
			for (int j = 0; j < 9; j++)
				r.ax[j] = 32'(clip(rnd(ax[j], 30), -AXIS_LIMIT, AXIS_LIMIT));
			if (ellipsoid) begin
				t1 = mulr(E2_Q62, mulr(slat, slat, 58), 62);
				denom = ONE_Q62 - t1;
				if (denom < DENOM_FLOOR_Q62) denom = DENOM_FLOOR_Q62;
				root = floor_root(denom);
				if (root == 0) root = 1;
				nroot = longint'((64'd6378137000 << 31) / root);
				nxy = nroot;
				if (lat > Q22_SIXTY_DEG || lat < -Q22_SIXTY_DEG) begin
					t2 = mulr(t1, t1, 62);
					t3 = mulr(t2, t1, 62);
					fac = ONE_Q62 + (t1 >>> 1) + ((3 * t2) >>> 3) + ((5 * t3) >>> 4);
					nxy = mulr(WGS84_A_MM, fac, 62);
				end
				pxy = nxy + longint'(f.alt);
				pz = mulr(nroot, ONE_Q62 - E2_Q62, 62) + longint'(f.alt);
			end else begin
				pxy = SPHERE_R_MM + longint'(f.alt);
				pz = pxy;
			end
			t = mulr(pxy, clat, 44);
			pos[0] = rnd(mulr(t, clon, 60), 16);
			pos[1] = rnd(mulr(t, slon, 60), 16);
			pos[2] = mulr(pz, slat, 60);
			for (int j = 0; j < 3; j++)
				r.org[j] = 37'(clip(pos[j], POS_MIN, POS_MAX));
			return r;
		endfunction

		function void note_fix(fix_t f);
			pending.push_back(transform(f));
		endfunction

		function void check_frame(logic [OUT_W-1:0] d);
			frame_t e;
			string names[12] = '{"east_x", "east_y", "east_z", "north_x", "north_y",
				"north_z", "up_x", "up_y", "up_z", "origin_x", "origin_y", "origin_z"};
			logic signed [36:0] got;
			checked++;
			if (pending.size() == 0) begin
				$error("frame arrived with none expected");
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int j = 0; j < 9; j++)
				if (d[32 * j +: 32] !== e.ax[j]) begin
					$error("%s expected %0d got %0d", names[j], e.ax[j],
						$signed(d[32 * j +: 32]));
					errors++;
				end
			for (int j = 0; j < 3; j++) begin
				got = d[288 + 37 * j +: 37];
				if (got !== e.org[j]) begin
					$error("%s expected %0d got %0d", names[9 + j], e.org[j], got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	frame_scoreboard frames;
	longint cycles;
	bit hold_off;
	int sent;

	geodetic_to_enu_frame_transform_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		frames = new();
		arst_n = 0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		hold_off = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			frames.check_frame(m_tdata);
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			g = (sent < 60) ? 0 : gap_len();
			if (g > 0) begin
				m_tready <= 0;
				repeat (g) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	task automatic write_mode(bit val);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_MODE; pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		frames.ellipsoid = val;
		@(posedge clk);
	endtask

	task automatic send_fix(fix_t f, bit no_gap);
		int g;
		g = no_gap ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= IN_W'(f);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		frames.note_fix(f);
		sent++;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (frames.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function fix_t random_fix();
		fix_t f;
		int r;
		r = $urandom_range(0, 9);
		f.lon = (r < 8) ? 31'($urandom_range(0, 1509949440) - 754974720) : 31'($urandom);
		f.lat = (r < 8) ? 30'($urandom_range(0, 754974720) - 377487360) : 30'($urandom);
		case ($urandom_range(0, 3))
			0: f.alt = $urandom;
			1: f.alt = 32'($urandom_range(0, 20000000)) - 32'sd1000000;
			default: f.alt = 32'($urandom_range(0, 20000000));
		endcase
		return f;
	endfunction

	initial begin
		fix_t dir[$];
		int lons[7] = '{0, 754974720, -754974720, 377487360, -377487360, 377487361, -1};
		int lats[6] = '{0, 377487360, -377487360, 251658240, 251658241, -251658241};
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < 7; i++) dir.push_back('{32'sd0, 30'sd0, 31'(lons[i])});
		for (int i = 0; i < 6; i++) dir.push_back('{32'sd100000, 30'(lats[i]), 31'sd1000});
		dir.push_back('{32'h7fffffff, 30'sd0, 31'sd0});
		dir.push_back('{32'h80000000, 30'sd0, 31'sd0});
		dir.push_back('{32'h7fffffff, 30'h1fffffff, 31'h3fffffff});
		dir.push_back('{32'h80000000, 30'h20000000, 31'h40000000});
		dir.push_back('{32'sd0, 30'sd377487359, 31'sd754974719});
		foreach (dir[i]) send_fix(dir[i], 1);
		drain();
		write_mode(0);
		foreach (dir[i]) send_fix(dir[i], 1);
		drain();
		write_mode(1);
		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) hold_off = 1;
			for (int i = 0; i < NUM_RANDOM / 4; i++)
				send_fix(random_fix(), ph == 1);
			drain();
			write_mode(ph % 2 == 0 ? 0 : 1);
		end
		$display("Sent %0d fixes, checked %0d frames, both Earth models and long output stalls.",
			sent, frames.checked);
		if (frames.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/g2e_pkg.sv
hw/rtl/g2e_mul.sv
hw/rtl/g2e_cordic_cell.sv
hw/rtl/g2e_root_cell.sv
hw/rtl/g2e_div_cell.sv
hw/rtl/geodetic_to_enu_frame_transform_top.sv
test/geodetic_to_enu_frame_transform_top_tb.sv
